[rtl/core/rtdc_pkg.sv]
// Shared types, widths and constants of the RTD linearisation pipeline.
// Holds the PT100 resistance table; no dependencies.
`default_nettype none

package rtdc_pkg;

  localparam int R_W     = 23;
  localparam int T_W     = 23;
  localparam int ROM_W   = 19;
  localparam int SEG_W   = 6;
  localparam int N_W     = 30;
  localparam int D_W     = 12;
  localparam int M_W     = 22;
  localparam int Q_W     = 22;
  localparam int BASE_W  = 17;
  localparam int SUM_W   = 24;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_SEL = 2;

  localparam int RTD_ENTRIES = 56;
  localparam int T_FIRST     = -5000;
  localparam int T_LAST      = 50000;
  localparam int T_STEP      = 1000;
  localparam int SLOPE_LOW   = 396;
  localparam int SLOPE_HIGH  = 333;
  localparam int SCALE_EDGE  = 100;
  localparam int SCALE_MID   = 1000;

  localparam int RECIP_SHIFT = 30;
  localparam int M_LOW       = (2 ** RECIP_SHIFT) / SLOPE_LOW;
  localparam int M_HIGH      = (2 ** RECIP_SHIFT) / SLOPE_HIGH;

  localparam int DIV10_SHIFT = 26;
  localparam logic [R_W-1:0] DIV10_MUL = 23'd6710887;

  localparam logic [0:0] REG_SENSOR_TYPE = 1'b0;
  localparam logic       SENSOR_PT1000   = 1'b1;

  localparam logic [ROM_W-1:0] RTD_ROM [RTD_ENTRIES] = '{
    19'd80306,  19'd84271,  19'd88222,  19'd92160,  19'd96086,
    19'd100000, 19'd103903, 19'd107794, 19'd111673, 19'd115541,
    19'd119397, 19'd123242, 19'd127075, 19'd130897, 19'd134707,
    19'd138506, 19'd142293, 19'd146068, 19'd149832, 19'd153584,
    19'd157325, 19'd161054, 19'd164772, 19'd168478, 19'd172173,
    19'd175856, 19'd179528, 19'd183188, 19'd186836, 19'd190473,
    19'd194098, 19'd197712, 19'd201314, 19'd204904, 19'd208483,
    19'd212050, 19'd215606, 19'd219150, 19'd222682, 19'd226203,
    19'd229712, 19'd233209, 19'd236695, 19'd240169, 19'd243631,
    19'd247082, 19'd250521, 19'd253948, 19'd257364, 19'd260768,
    19'd264160, 19'd267540, 19'd270909, 19'd274266, 19'd277611,
    19'd280944
  };

  localparam logic [ROM_W-1:0] R_FIRST = RTD_ROM[0];
  localparam logic [ROM_W-1:0] R_LAST  = RTD_ROM[RTD_ENTRIES-1];

  typedef struct packed {
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
  } apb_req_t;

  typedef struct packed {
    logic [N_W-1:0]           n;
    logic [D_W-1:0]           d;
    logic [M_W-1:0]           m;
    logic signed [BASE_W-1:0] base;
    logic                     neg;
  } div_op_t;

endpackage

`default_nettype wire

[rtl/core/rtdc_cfg.sv]
// Configuration register file: sensor type behind an APB-style port.
// Depends on rtdc_pkg.
`default_nettype none

module rtdc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rtdc_pkg::apb_req_t              apb,
  output logic [rtdc_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  output logic                            sensor_type
);
  import rtdc_pkg::*;

  logic sensor_type_r;
  logic sensor_type_nxt;
  logic sel_sensor;

  assign sel_sensor = (apb.paddr[REG_SEL] == REG_SENSOR_TYPE);

  always_comb begin
    sensor_type_nxt = sensor_type_r;
    if (apb.psel && apb.penable && apb.pwrite && sel_sensor) begin
      sensor_type_nxt = apb.pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_type_r <= 1'b0;
    end else begin
      sensor_type_r <= sensor_type_nxt;
    end
  end

  assign prdata      = sel_sensor ? {{(PDATA_W-1){1'b0}}, sensor_type_r} : '0;
  assign pready      = 1'b1;
  assign sensor_type = sensor_type_r;

endmodule

`default_nettype wire

[rtl/core/rtdc_seg.sv]
// Interval search and divide operand set-up (two pipeline stages).
// Depends on rtdc_pkg for the resistance table and operand struct.
`default_nettype none

module rtdc_seg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        v_i,
  input  logic [rtdc_pkg::R_W-1:0]    r_i,
  input  logic                        ready_i,
  output logic                        ready_o,
  output logic                        v_o,
  output rtdc_pkg::div_op_t           op_o
);
  import rtdc_pkg::*;

  logic [D_W-1:0]           d_tab [RTD_ENTRIES-1];
  logic [M_W-1:0]           m_tab [RTD_ENTRIES-1];
  logic signed [BASE_W-1:0] b_tab [RTD_ENTRIES-1];

  for (genvar g = 0; g < RTD_ENTRIES - 1; g++) begin : g_seg
    localparam int D = int'(RTD_ROM[g+1]) - int'(RTD_ROM[g]);
    localparam int M = (2 ** RECIP_SHIFT) / D;
    localparam int B = T_FIRST + g * T_STEP;
    assign d_tab[g] = D_W'(D);
    assign m_tab[g] = M_W'(M);
    assign b_tab[g] = BASE_W'(B);
  end

  logic             en3;
  logic             en4;
  logic             v3_r;
  logic [R_W-1:0]   r3_r;
  logic             low3_r;
  logic             high3_r;
  logic [SEG_W-1:0] seg3_r;
  logic [SEG_W-1:0] seg_nxt;
  logic             v4_r;
  div_op_t          op4_r;
  div_op_t          op_nxt;
  logic [R_W-1:0]   diff;
  logic [R_W-1:0]   rom_lo;

  assign en4     = !v4_r || ready_i;
  assign en3     = !v3_r || en4;
  assign ready_o = en3;

  always_comb begin
    seg_nxt = '0;
    for (int i = 1; i < RTD_ENTRIES - 1; i++) begin
      if (r_i >= R_W'(RTD_ROM[i])) begin
        seg_nxt = SEG_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v_i) begin
      r3_r    <= r_i;
      low3_r  <= (r_i <= R_W'(R_FIRST));
      high3_r <= (r_i >= R_W'(R_LAST));
      seg3_r  <= seg_nxt;
    end
  end

  assign rom_lo = R_W'(RTD_ROM[seg3_r]);

  always_comb begin
    op_nxt = '0;
    if (low3_r) begin
      diff        = R_W'(R_FIRST) - r3_r;
      op_nxt.n    = N_W'(diff) * N_W'(SCALE_EDGE);
      op_nxt.d    = D_W'(SLOPE_LOW);
      op_nxt.m    = M_W'(M_LOW);
      op_nxt.base = BASE_W'(T_FIRST);
      op_nxt.neg  = 1'b1;
    end else if (high3_r) begin
      diff        = r3_r - R_W'(R_LAST);
      op_nxt.n    = N_W'(diff) * N_W'(SCALE_EDGE);
      op_nxt.d    = D_W'(SLOPE_HIGH);
      op_nxt.m    = M_W'(M_HIGH);
      op_nxt.base = BASE_W'(T_LAST);
      op_nxt.neg  = 1'b0;
    end else begin
      diff        = r3_r - rom_lo;
      op_nxt.n    = N_W'(diff) * N_W'(SCALE_MID);
      op_nxt.d    = d_tab[seg3_r];
      op_nxt.m    = m_tab[seg3_r];
      op_nxt.base = b_tab[seg3_r];
      op_nxt.neg  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      op4_r <= op_nxt;
    end
  end

  assign v_o  = v4_r;
  assign op_o = op4_r;

endmodule

`default_nettype wire

[rtl/core/rtdc_div.sv]
// Reciprocal divider with remainder correction and output register.
// Three pipeline stages; depends on rtdc_pkg.
`default_nettype none

module rtdc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              v_i,
  input  rtdc_pkg::div_op_t                 op_i,
  input  logic                              ready_i,
  output logic                              ready_o,
  output logic                              out_valid,
  output logic signed [rtdc_pkg::T_W-1:0]   out_temp
);
  import rtdc_pkg::*;

  logic                  en5;
  logic                  en6;
  logic                  en7;
  logic                  v5_r;
  div_op_t               op5_r;
  logic [Q_W-1:0]        est5_r;
  logic [N_W+M_W-1:0]    prod_nm;
  logic                  v6_r;
  div_op_t               op6_r;
  logic [Q_W-1:0]        est6_r;
  logic [N_W-1:0]        pd6_r;
  logic [Q_W+D_W-1:0]    prod_qd;
  logic [N_W-1:0]        rem;
  logic                  corr;
  logic [Q_W-1:0]        q;
  logic signed [SUM_W-1:0] base_x;
  logic signed [SUM_W-1:0] q_x;
  logic signed [SUM_W-1:0] t;
  logic                  out_valid_r;
  logic signed [T_W-1:0] out_temp_r;

  assign en7     = !out_valid_r || ready_i;
  assign en6     = !v6_r || en7;
  assign en5     = !v5_r || en6;
  assign ready_o = en5;

  assign prod_nm = (N_W+M_W)'(op_i.n) * (N_W+M_W)'(op_i.m);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en5) begin
      v5_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en5 && v_i) begin
      op5_r  <= op_i;
      est5_r <= prod_nm[RECIP_SHIFT +: Q_W];
    end
  end

  assign prod_qd = (Q_W+D_W)'(est5_r) * (Q_W+D_W)'(op5_r.d);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en6) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en6 && v5_r) begin
      op6_r  <= op5_r;
      est6_r <= est5_r;
      pd6_r  <= prod_qd[N_W-1:0];
    end
  end

  assign rem    = op6_r.n - pd6_r;
  assign corr   = (rem >= N_W'(op6_r.d));
  assign q      = est6_r + Q_W'(corr);
  assign base_x = SUM_W'(op6_r.base);
  assign q_x    = signed'(SUM_W'(q));
  assign t      = op6_r.neg ? (base_x - q_x) : (base_x + q_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en7) begin
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en7 && v6_r) begin
      out_temp_r <= t[T_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_temp  = out_temp_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r |-> (rem < {op6_r.d, 1'b0}))
    else $error("remainder out of correction range");

  a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (v6_r && !en7) |=> v6_r)
    else $error("stalled transaction dropped from stage six");

  a_low_side: assert property (@(posedge clk) disable iff (!rst_n)
    (v6_r && op6_r.neg) |-> (t <= SUM_W'(T_FIRST)))
    else $error("low-side result above first table temperature");

endmodule

`default_nettype wire

[rtl/core/rtd_resistance_to_temperature.sv]
// RTD linearisation top level: resistance in milliohms to temperature in 0.01 degC.
// The pipeline has seven register stages.
// Throughput: one transaction per cycle while out_stall is low.
// Stages hold under out_stall and empty stages still fill, so bubbles are squeezed out.
// Reset (synchronous, active low) empties the pipeline and selects PT100 mode.
// Depends on rtdc_pkg, rtdc_cfg, rtdc_seg and rtdc_div.
`default_nettype none

module rtd_resistance_to_temperature (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [rtdc_pkg::R_W-1:0]               in_resistance_mohm,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rtdc_pkg::T_W-1:0]        out_temperature_centideg,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [rtdc_pkg::PADDR_W-1:0]           paddr,
  input  logic [rtdc_pkg::PDATA_W-1:0]           pwdata,
  output logic [rtdc_pkg::PDATA_W-1:0]           prdata,
  output logic                                   pready
);
  import rtdc_pkg::*;

  apb_req_t           apb;
  logic               sensor_type;
  logic               en1;
  logic               en2;
  logic               v1_r;
  logic [R_W-1:0]     r1_r;
  logic               pt1k1_r;
  logic [2*R_W-1:0]   div10_prod;
  logic [R_W-1:0]     r2_nxt;
  logic               v2_r;
  logic [R_W-1:0]     r2_r;
  logic               seg_ready;
  logic               seg_v;
  div_op_t            seg_op;
  logic               div_ready;

  assign apb.psel    = psel;
  assign apb.penable = penable;
  assign apb.pwrite  = pwrite;
  assign apb.paddr   = paddr;
  assign apb.pwdata  = pwdata;

  rtdc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .apb         (apb),
    .prdata      (prdata),
    .pready      (pready),
    .sensor_type (sensor_type)
  );

  assign en2      = !v2_r || seg_ready;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      r1_r    <= in_resistance_mohm;
      pt1k1_r <= (sensor_type == SENSOR_PT1000);
    end
  end

  assign div10_prod = (2*R_W)'(r1_r) * (2*R_W)'(DIV10_MUL);
  assign r2_nxt     = pt1k1_r ? R_W'(div10_prod[2*R_W-1:DIV10_SHIFT]) : r1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      r2_r <= r2_nxt;
    end
  end

  rtdc_seg u_seg (
    .clk     (clk),
    .rst_n   (rst_n),
    .v_i     (v2_r),
    .r_i     (r2_r),
    .ready_i (div_ready),
    .ready_o (seg_ready),
    .v_o     (seg_v),
    .op_o    (seg_op)
  );

  rtdc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .v_i       (seg_v),
    .op_i      (seg_op),
    .ready_i   (!out_stall),
    .ready_o   (div_ready),
    .out_valid (out_valid),
    .out_temp  (out_temperature_centideg)
  );

endmodule

`default_nettype wire

[tb/rtd_resistance_to_temperature_tb.sv]
// Self-checking testbench for the RTD resistance to temperature linearisation pipeline.
// Predicts each temperature from its own PT100 table and checks every output transaction.
// Depends on rtdc_pkg for port widths; drives the APB-style register port directly.
`timescale 1ns / 100ps

module rtd_resistance_to_temperature_tb;

  import rtdc_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_LEN      = 200;
  localparam int TAIL_CYCLES   = 20;
  localparam int BATCH_ITEMS   = 110;
  localparam int SQUEEZE_ITEMS = 150;

  localparam logic [PADDR_W-1:0] ADDR_SENSOR_TYPE = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_SPARE       = 3'd4;

  localparam int TABLE_LEN   = 56;
  localparam int CD_AT_FIRST = -5000;
  localparam int CD_AT_LAST  = 50000;
  localparam int CD_PER_STEP = 1000;
  localparam int CD_EDGE     = 100;
  localparam int MOHM_PER_DEG_COLD = 396;
  localparam int MOHM_PER_DEG_HOT  = 333;
  localparam int PT1000_DIV  = 10;

  localparam int PT100_MOHM [TABLE_LEN] = '{
    80306,  84271,  88222,  92160,  96086,  100000, 103903, 107794,
    111673, 115541, 119397, 123242, 127075, 130897, 134707, 138506,
    142293, 146068, 149832, 153584, 157325, 161054, 164772, 168478,
    172173, 175856, 179528, 183188, 186836, 190473, 194098, 197712,
    201314, 204904, 208483, 212050, 215606, 219150, 222682, 226203,
    229712, 233209, 236695, 240169, 243631, 247082, 250521, 253948,
    257364, 260768, 264160, 267540, 270909, 274266, 277611, 280944
  };

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic [R_W-1:0] mohm;
    logic [T_W-1:0] centideg;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [R_W-1:0]     in_resistance_mohm = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [T_W-1:0] out_temperature_centideg;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic [R_W-1:0] pending_mohm [$];
  reading_t       awaited [$];
  reading_t       head;
  bit             cfg_pt1000 = 1'b0;
  int unsigned    src_idle_pct = 0;
  int unsigned    snk_stall_pct = 0;
  bit             hold_armed = 1'b0;
  int             hold_cycles = 0;
  logic           hold_active;
  int             fault_count = 0;
  int             cycles = 0;

  int pt100_cases [$] = '{0, 1, 40000, 80305, 80306, 80307, 84270, 84271, 84272, 100000,
                          138506, 175000, 200000, 277610, 277611, 280943, 280944, 280945,
                          281277, 1234567, 4194304, 8388607};
  int pt1000_cases [$] = '{0, 9, 10, 803059, 803060, 803069, 803070, 1000000, 1385069,
                           2776119, 2809439, 2809440, 2809449, 2809450, 4194303, 8388607};
  int spare_cases [$] = '{803060, 2809440};

  rtd_resistance_to_temperature dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_resistance_mohm       (in_resistance_mohm),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_temperature_centideg (out_temperature_centideg),
    .psel                     (psel),
    .penable                  (penable),
    .pwrite                   (pwrite),
    .paddr                    (paddr),
    .pwdata                   (pwdata),
    .prdata                   (prdata),
    .pready                   (pready)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic [T_W-1:0] centideg_of(logic [R_W-1:0] raw, bit pt1000);
    longint r;
    longint t;
    int seg;
    r = raw;
    if (pt1000) r = r / PT1000_DIV;
    if (r <= PT100_MOHM[0]) begin
      t = CD_AT_FIRST + ((r - PT100_MOHM[0]) * CD_EDGE) / MOHM_PER_DEG_COLD;
    end else if (r >= PT100_MOHM[TABLE_LEN-1]) begin
      t = CD_AT_LAST + ((r - PT100_MOHM[TABLE_LEN-1]) * CD_EDGE) / MOHM_PER_DEG_HOT;
    end else begin
      seg = 0;
      for (int i = 1; i < TABLE_LEN - 1; i++)
        if (PT100_MOHM[i] <= r) seg = i;
      t = CD_AT_FIRST + longint'(seg) * CD_PER_STEP
          + ((r - PT100_MOHM[seg]) * CD_PER_STEP) / (PT100_MOHM[seg+1] - PT100_MOHM[seg]);
    end
    return t[T_W-1:0];
  endfunction

  function automatic logic [R_W-1:0] pick_resistance(bit pt1000);
    int unsigned roll;
    longint scale;
    longint r;
    scale = pt1000 ? PT1000_DIV : 1;
    roll = $urandom_range(99);
    if (roll < 30) begin
      r = longint'(PT100_MOHM[$urandom_range(TABLE_LEN - 1)]) * scale
          + longint'($urandom_range(12 * scale)) - 6 * scale;
    end else if (roll < 65) begin
      r = $urandom_range(300000 * scale, 70000 * scale);
    end else if (roll < 75) begin
      r = $urandom_range(90000 * scale);
    end else begin
      r = $urandom_range(23'h7FFFFF);
    end
    return r[R_W-1:0];
  endfunction

  // sender: hold a stalled transaction, otherwise advance or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        awaited.push_back('{in_resistance_mohm, centideg_of(in_resistance_mohm, cfg_pt1000)});
      if (!in_valid || !in_stall) begin
        if (pending_mohm.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid <= 1'b1;
          in_resistance_mohm <= pending_mohm.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!hold_armed) hold_cycles <= 0;
    else if (hold_cycles != HOLD_LEN) hold_cycles <= hold_cycles + 1;
  end

  assign hold_active = hold_armed && hold_cycles != HOLD_LEN;

  // receiver: check each transaction against the oldest expected temperature
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          $display("%0t: unexpected temperature %0d", $time, out_temperature_centideg);
          fault_count++;
        end else begin
          head = awaited.pop_front();
          if (out_temperature_centideg !== head.centideg) begin
            $display("%0t: temperature for %0d mOhm: expected %0d, actual %0d", $time,
                     head.mohm, $signed(head.centideg), out_temperature_centideg);
            fault_count++;
          end
        end
      end
      out_stall <= hold_active || ($urandom_range(99) < snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d transactions outstanding", $time, awaited.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        src_idle_pct = 0;
        snk_stall_pct = 0;
      end
      IDLE_SENDER: begin
        src_idle_pct = 53;
        snk_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        src_idle_pct = 0;
        snk_stall_pct = 53;
      end
      default: begin
        src_idle_pct = 11;
        snk_stall_pct = 11;
      end
    endcase
  endtask

  task automatic wait_drained();
    while (pending_mohm.size() != 0 || in_valid || awaited.size() != 0) @(negedge clk);
  endtask

  task automatic reg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    if (addr == ADDR_SENSOR_TYPE) cfg_pt1000 = data[0];
  endtask

  task automatic check_sensor_type();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_SENSOR_TYPE;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (!pready || prdata !== {{(PDATA_W-1){1'b0}}, cfg_pt1000}) begin
      $display("%0t: sensor_type read: expected %0d, actual %0h", $time, cfg_pt1000, prdata);
      fault_count++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_cases(int cases [$]);
    set_idle(IDLE_NONE);
    foreach (cases[i]) pending_mohm.push_back(cases[i][R_W-1:0]);
    wait_drained();
  endtask

  task automatic run_random(idle_mode_e mode, int count);
    set_idle(mode);
    repeat (count) pending_mohm.push_back(pick_resistance(cfg_pt1000));
    wait_drained();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    reg_write(ADDR_SENSOR_TYPE, 32'd0);
    check_sensor_type();
    run_cases(pt100_cases);

    reg_write(ADDR_SPARE, 32'd1);
    check_sensor_type();
    run_cases(spare_cases);

    reg_write(ADDR_SENSOR_TYPE, 32'hFFFF_FFFE);
    check_sensor_type();
    reg_write(ADDR_SENSOR_TYPE, 32'hFFFF_FFFF);
    check_sensor_type();
    run_cases(pt1000_cases);

    for (int p = 0; p < 8; p++) begin
      reg_write(ADDR_SENSOR_TYPE, p % 2);
      check_sensor_type();
      run_random(idle_mode_e'(p / 2), BATCH_ITEMS);
    end

    // hold the output back long enough to back the pipeline up into in_stall
    reg_write(ADDR_SENSOR_TYPE, $urandom_range(1));
    check_sensor_type();
    hold_armed = 1'b1;
    run_random(IDLE_NONE, SQUEEZE_ITEMS);
    hold_armed = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
